// ===== src/bdrs_pkg.sv =====
// ============================================================================
// bdrs_pkg
// Shared types and constants of the block-decomposed range-sum store: sizes,
// derived address widths, request and reply codes, sequencer states.
// ============================================================================
package bdrs_pkg;

  // payload widths fixed by the interface
  localparam int IDX_W  = 10;
  localparam int DATA_W = 32;

  // store geometry (BLOCK_SIZE is a power of two, NUM_ELEMENTS <= 2**IDX_W)
  localparam int NUM_ELEMENTS = 1024;
  localparam int BLOCK_SIZE   = 32;
  localparam int NUM_BLOCKS   = (NUM_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int BLK_SHIFT    = $clog2(BLOCK_SIZE);
  localparam int ELEM_AW      = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
  localparam int BLK_AW       = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  // walk cursor can step one past the last index
  localparam int CUR_W  = IDX_W + 1;
  localparam int SPAN_W = CUR_W + 1;

  localparam logic [CUR_W-1:0] LAST_ELEM = CUR_W'(NUM_ELEMENTS - 1);

  // request codes
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // reply codes
  localparam logic REPLY_ACK = 1'b0;
  localparam logic REPLY_SUM = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_QUERY,
    ST_DRAIN,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] sum;
    logic              bad;
  } reply_t;

  typedef struct packed {
    logic busy;
    logic done;
  } eng_status_t;

endpackage

// ===== src/bdrs_ram.sv =====
// ============================================================================
// bdrs_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ============================================================================
module bdrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/bdrs_engine.sv =====
// ============================================================================
// bdrs_engine
// Sequencer and datapath around the element memory and the block-sum memory:
// clearing pass after reset, read-modify-write for updates, range walk with
// a running accumulator for queries.
// ============================================================================
module bdrs_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic                       req_type,
  input  logic [bdrs_pkg::IDX_W-1:0] first_index,
  input  logic [bdrs_pkg::IDX_W-1:0] last_index,
  input  logic [bdrs_pkg::DATA_W-1:0] new_value,
  input  logic                       out_free,
  output bdrs_pkg::reply_t           reply,
  output bdrs_pkg::eng_status_t      status
);

  import bdrs_pkg::*;

  state_t state, state_next;

  // transaction registers
  logic              kind_q;
  logic              bad_q;
  logic [IDX_W-1:0]  lo_q;
  logic [CUR_W-1:0]  hi_q;
  logic [DATA_W-1:0] val_q;
  logic [CUR_W-1:0]  cursor;
  logic [DATA_W-1:0] acc;
  logic              rd_pend;
  logic              rd_blk;
  logic [ELEM_AW-1:0] clr_addr;

  // memory ports
  logic               elem_we;
  logic [ELEM_AW-1:0] elem_waddr;
  logic [DATA_W-1:0]  elem_wdata;
  logic [ELEM_AW-1:0] elem_raddr;
  logic [DATA_W-1:0]  elem_rd;
  logic               blk_we;
  logic [BLK_AW-1:0]  blk_waddr;
  logic [DATA_W-1:0]  blk_wdata;
  logic [BLK_AW-1:0]  blk_raddr;
  logic [DATA_W-1:0]  blk_rd;

  // request decode
  logic             accept;
  logic [CUR_W-1:0] lo_ext;
  logic [CUR_W-1:0] hi_ext;
  logic [CUR_W-1:0] hi_sat;
  logic             reversed;
  logic             upd_in_range;

  // walk step decode
  logic              step_blk;
  logic [SPAN_W-1:0] blk_end;
  logic [CUR_W-1:0]  cursor_step;
  logic              clr_last;

  assign accept       = (state == ST_IDLE) && req_valid;
  assign lo_ext       = {1'b0, first_index};
  assign hi_ext       = {1'b0, last_index};
  assign hi_sat       = (hi_ext > LAST_ELEM) ? LAST_ELEM : hi_ext;
  assign reversed     = first_index > last_index;
  assign upd_in_range = lo_ext <= LAST_ELEM;

  // whole block when aligned and the block ends inside the range
  assign blk_end     = {1'b0, cursor} + SPAN_W'(BLOCK_SIZE - 1);
  assign step_blk    = (cursor[BLK_SHIFT-1:0] == '0) && (blk_end <= {1'b0, hi_q});
  assign cursor_step = step_blk ? cursor + CUR_W'(BLOCK_SIZE) : cursor + CUR_W'(1);
  assign clr_last    = clr_addr == ELEM_AW'(NUM_ELEMENTS - 1);

  // memories
  bdrs_ram #(.WIDTH(DATA_W), .DEPTH(NUM_ELEMENTS)) u_elem_ram (
    .clk   (clk),
    .we    (elem_we),
    .waddr (elem_waddr),
    .wdata (elem_wdata),
    .raddr (elem_raddr),
    .rdata (elem_rd)
  );

  bdrs_ram #(.WIDTH(DATA_W), .DEPTH(NUM_BLOCKS)) u_blk_ram (
    .clk   (clk),
    .we    (blk_we),
    .waddr (blk_waddr),
    .wdata (blk_wdata),
    .raddr (blk_raddr),
    .rdata (blk_rd)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          priority if (req_type == REQ_UPDATE) begin
            state_next = upd_in_range ? ST_UPD_RD : ST_REPLY;
          end else if (reversed || (lo_ext > hi_sat)) begin
            state_next = ST_REPLY;
          end else begin
            state_next = ST_QUERY;
          end
        end
      end
      ST_UPD_RD: state_next = ST_UPD_WR;
      ST_UPD_WR: state_next = ST_REPLY;
      ST_QUERY: begin
        if (cursor_step > hi_q) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_REPLY;
      ST_REPLY: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // memory controls and status
  always_comb begin
    elem_we     = 1'b0;
    elem_waddr  = lo_q[ELEM_AW-1:0];
    elem_wdata  = val_q;
    elem_raddr  = lo_q[ELEM_AW-1:0];
    blk_we      = 1'b0;
    blk_waddr   = lo_q[BLK_SHIFT +: BLK_AW];
    blk_wdata   = blk_rd + val_q - elem_rd;
    blk_raddr   = lo_q[BLK_SHIFT +: BLK_AW];
    status.busy = state != ST_IDLE;
    status.done = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        elem_we    = 1'b1;
        elem_waddr = clr_addr;
        elem_wdata = '0;
        blk_we     = clr_addr < ELEM_AW'(NUM_BLOCKS);
        blk_waddr  = clr_addr[BLK_AW-1:0];
        blk_wdata  = '0;
      end
      ST_UPD_WR: begin
        elem_we = 1'b1;
        blk_we  = 1'b1;
      end
      ST_QUERY: begin
        elem_raddr = cursor[ELEM_AW-1:0];
        blk_raddr  = cursor[BLK_SHIFT +: BLK_AW];
      end
      ST_REPLY: begin
        status.done = out_free;
      end
      default: begin
      end
    endcase
  end

  assign reply.kind = kind_q;
  assign reply.sum  = acc;
  assign reply.bad  = bad_q;

  // sequencer state and clearing counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      rd_pend  <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= state == ST_QUERY;
      if (state == ST_CLEAR) clr_addr <= clr_addr + ELEM_AW'(1);
    end
  end

  // transaction capture, range walk and accumulator
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= req_type;
      bad_q  <= (req_type == REQ_QUERY) && reversed;
      lo_q   <= first_index;
      hi_q   <= hi_sat;
      val_q  <= new_value;
      cursor <= lo_ext;
      acc    <= '0;
    end else begin
      if (state == ST_QUERY) begin
        cursor <= cursor_step;
        rd_blk <= step_blk;
      end
      if (rd_pend) acc <= acc + (rd_blk ? blk_rd : elem_rd);
    end
  end

endmodule

// ===== src/block_decomposed_range_sum.sv =====
// ============================================================================
// block_decomposed_range_sum
// Range-sum store over signed 32-bit elements with one running sum per block.
// ============================================================================
// Usage:
//   Request channel (req_valid / req_stall) carries req_type, first_index,
//   last_index and new_value. Reply channel (reply_valid / reply_stall)
//   returns reply_kind, range_sum and bad_range, one reply per request,
//   in request order. A transaction moves on a rising edge with valid high
//   and stall low.
//   An update reads the element and its block sum, then writes both back;
//   the reply is loaded into the output register after the write.
//   A query walks the range through the memory read ports: single elements
//   in partial edge blocks, one block sum per whole block, one read a cycle.
//   The reply follows the last read through a drain state; a query makes at
//   most about 2*BLOCK_SIZE + NUM_BLOCKS reads (under 100 at 1024/32).
//   One request is worked at a time; req_stall is high while one is in work.
//   After reset a clearing pass zeroes both memories with req_stall held high.
//   A reply waiting under reply_stall sits in the output register; the
//   next request is taken and worked meanwhile, and its reply waits in the
//   engine until the register frees.
// ============================================================================
module block_decomposed_range_sum (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic                        req_type,
  input  logic [bdrs_pkg::IDX_W-1:0]  first_index,
  input  logic [bdrs_pkg::IDX_W-1:0]  last_index,
  input  logic signed [bdrs_pkg::DATA_W-1:0] new_value,
  output logic                        reply_valid,
  input  logic                        reply_stall,
  output logic                        reply_kind,
  output logic signed [bdrs_pkg::DATA_W-1:0] range_sum,
  output logic                        bad_range
);

  import bdrs_pkg::*;

  reply_t      reply;
  eng_status_t status;
  logic        out_free;

  assign out_free  = !reply_valid || !reply_stall;
  assign req_stall = status.busy;

  bdrs_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_type    (req_type),
    .first_index (first_index),
    .last_index  (last_index),
    .new_value   (new_value),
    .out_free    (out_free),
    .reply       (reply),
    .status      (status)
  );

  // reply output register
  always_ff @(posedge clk) begin
    if (rst) begin
      reply_valid <= 1'b0;
    end else if (status.done) begin
      reply_valid <= 1'b1;
    end else if (!reply_stall) begin
      reply_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.done) begin
      reply_kind <= reply.kind;
      range_sum  <= reply.sum;
      bad_range  <= reply.bad;
    end
  end

  // checks
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    status.done |-> (!reply_valid || !reply_stall))
    else $error("reply loaded over a waiting reply");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("engine not busy after request transaction");

  a_bad_is_query: assert property (@(posedge clk) disable iff (rst)
    (reply_valid && bad_range) |-> (reply_kind == REPLY_SUM && range_sum == '0))
    else $error("bad range reply with nonzero sum or wrong kind");

  a_ack_is_zero: assert property (@(posedge clk) disable iff (rst)
    (reply_valid && reply_kind == REPLY_ACK) |-> (range_sum == '0 && !bad_range))
    else $error("update acknowledge carries data");

endmodule

// ===== dv/block_decomposed_range_sum_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// block_decomposed_range_sum_tb
// Drives element updates and range-sum queries through the request channel
// and checks every reply against a shadow copy of the element store and the
// per-block sums. A directed table covers the extremes and reversed ranges.
// A random mix follows, with idle gaps and reply backpressure on both sides.
// ============================================================================
module block_decomposed_range_sum_tb;
  import bdrs_pkg::*;

  localparam int RANDOM_ITEMS = 600;
  localparam int TAIL_CYCLES  = 4 + 2 * BLOCK_SIZE + NUM_BLOCKS;
  localparam int STALL_LIMIT  = 4 * (NUM_ELEMENTS + 2 * BLOCK_SIZE + NUM_BLOCKS + 160);
  localparam int IDX_MAX      = (1 << IDX_W) - 1;
  localparam int MAX_PRINTS   = 100;

  typedef struct {
    logic              kind;
    logic [IDX_W-1:0]  lo;
    logic [IDX_W-1:0]  hi;
    logic [DATA_W-1:0] val;
    bit                typed;
    reply_t            want;
  } req_row_t;

  logic                     clk;
  logic                     rst;
  logic                     req_valid;
  logic                     req_stall;
  logic                     req_type;
  logic [IDX_W-1:0]         first_index;
  logic [IDX_W-1:0]         last_index;
  logic signed [DATA_W-1:0] new_value;
  logic                     reply_valid;
  logic                     reply_stall = 1'b0;
  logic                     reply_kind;
  logic signed [DATA_W-1:0] range_sum;
  logic                     bad_range;

  // shadow copy of both stores
  logic [DATA_W-1:0] shadow_elems [NUM_ELEMENTS];
  logic [DATA_W-1:0] shadow_block_sums [NUM_BLOCKS];

  reply_t   owed_replies[$];
  req_row_t directed_rows[$];
  int       fail_count = 0;
  int       reply_no = 0;
  int       idle_cycles = 0;
  int       stall_left = 0;
  bit       quiet = 0;

  block_decomposed_range_sum DUT (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_type    (req_type),
    .first_index (first_index),
    .last_index  (last_index),
    .new_value   (new_value),
    .reply_valid (reply_valid),
    .reply_stall (reply_stall),
    .reply_kind  (reply_kind),
    .range_sum   (range_sum),
    .bad_range   (bad_range)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(string what);
    fail_count++;
    if (fail_count <= MAX_PRINTS) begin
      $display("%0t mismatch: %s", $time, what);
    end
  endtask

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 150);
  endfunction

  // apply one transaction to the shadow stores and work out its reply
  function automatic reply_t predict_reply(logic kind, logic [IDX_W-1:0] lo,
                                           logic [IDX_W-1:0] hi, logic [DATA_W-1:0] val);
    reply_t            r;
    logic [DATA_W-1:0] acc;
    int                top;
    int                fb;
    int                lb;
    r.kind = (kind == REQ_QUERY) ? REPLY_SUM : REPLY_ACK;
    r.sum  = '0;
    r.bad  = 1'b0;
    acc    = '0;
    if (kind == REQ_UPDATE) begin
      // out-of-range update is acknowledged and dropped
      if (int'(lo) < NUM_ELEMENTS) begin
        shadow_block_sums[int'(lo) / BLOCK_SIZE] += val - shadow_elems[lo];
        shadow_elems[lo] = val;
      end
    end else if (lo > hi) begin
      r.bad = 1'b1;
    end else begin
      // right bound saturates at the last element
      top = (int'(hi) >= NUM_ELEMENTS) ? NUM_ELEMENTS - 1 : int'(hi);
      if (int'(lo) <= top) begin
        fb = int'(lo) / BLOCK_SIZE;
        lb = top / BLOCK_SIZE;
        if (fb == lb) begin
          for (int i = int'(lo); i <= top; i++) acc += shadow_elems[i];
        end else begin
          for (int i = int'(lo); i < (fb + 1) * BLOCK_SIZE; i++) acc += shadow_elems[i];
          for (int b = fb + 1; b < lb; b++) acc += shadow_block_sums[b];
          for (int i = lb * BLOCK_SIZE; i <= top; i++) acc += shadow_elems[i];
        end
      end
      r.sum = acc;
    end
    return r;
  endfunction

  function automatic req_row_t mk_row(logic kind, int lo, int hi, logic [DATA_W-1:0] val,
                                      bit typed = 1'b0, logic [DATA_W-1:0] sum = '0,
                                      logic bad = 1'b0);
    req_row_t r;
    r.kind      = kind;
    r.lo        = IDX_W'(lo);
    r.hi        = IDX_W'(hi);
    r.val       = val;
    r.typed     = typed;
    r.want.kind = (kind == REQ_QUERY) ? REPLY_SUM : REPLY_ACK;
    r.want.sum  = sum;
    r.want.bad  = bad;
    return r;
  endfunction

  // random transaction: updates spread and clustered, queries of every shape
  function automatic req_row_t random_row();
    req_row_t r;
    int       lo;
    int       hi;
    int       base;
    logic [DATA_W-1:0] val;
    val = $urandom();
    if ($urandom_range(0, 99) < 45) begin
      case ($urandom_range(0, 3))
        0: lo = $urandom_range(0, 127);
        1: lo = $urandom_range(0, NUM_BLOCKS - 1) * BLOCK_SIZE
                + ($urandom_range(0, 1) ? BLOCK_SIZE - 1 : 0);
        default: lo = $urandom_range(0, IDX_MAX);
      endcase
      hi = $urandom_range(0, IDX_MAX);
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: val = 32'h7FFF_FFFF;
          1: val = 32'h8000_0000;
          2: val = '1;
          default: val = '0;
        endcase
      end
      r = mk_row(REQ_UPDATE, lo, hi, val);
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          base = $urandom_range(0, NUM_BLOCKS - 1) * BLOCK_SIZE;
          lo   = base + $urandom_range(0, BLOCK_SIZE - 1);
          hi   = $urandom_range(lo, base + BLOCK_SIZE - 1);
        end
        3, 4: begin
          lo = $urandom_range(0, IDX_MAX);
          hi = lo + $urandom_range(BLOCK_SIZE, 4 * BLOCK_SIZE);
          if (hi > IDX_MAX) hi = IDX_MAX;
        end
        5: begin
          lo = $urandom_range(0, 2 * BLOCK_SIZE);
          hi = $urandom_range(IDX_MAX - 2 * BLOCK_SIZE, IDX_MAX);
        end
        6: begin
          lo = $urandom_range(0, IDX_MAX);
          hi = lo;
        end
        7: begin
          hi = $urandom_range(0, IDX_MAX - 1);
          lo = $urandom_range(hi + 1, IDX_MAX);
        end
        default: begin
          lo = $urandom_range(0, IDX_MAX);
          hi = $urandom_range(0, IDX_MAX);
        end
      endcase
      r = mk_row(REQ_QUERY, lo, hi, val);
    end
    return r;
  endfunction

  // present one transaction and hold it until taken
  task automatic send_req(req_row_t row);
    int     gap;
    reply_t guess;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid   <= 1'b1;
    req_type    <= row.kind;
    first_index <= row.lo;
    last_index  <= row.hi;
    new_value   <= row.val;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    guess = predict_reply(row.kind, row.lo, row.hi, row.val);
    owed_replies.push_back(row.typed ? row.want : guess);
  endtask

  // hold off the sender until every owed reply is back
  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (owed_replies.size() != 0);
  endtask

  // stimulus
  initial begin
    rst         = 1'b1;
    req_valid   = 1'b0;
    req_type    = REQ_UPDATE;
    first_index = '0;
    last_index  = '0;
    new_value   = '0;
    foreach (shadow_elems[i]) shadow_elems[i] = '0;
    foreach (shadow_block_sums[i]) shadow_block_sums[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // after reset, extremes, wraparound, reversed ranges, block edges
    directed_rows.push_back(mk_row(REQ_QUERY, 0, IDX_MAX, '0, 1, '0, 0));
    directed_rows.push_back(mk_row(REQ_QUERY, IDX_MAX, IDX_MAX, '0, 1, '0, 0));
    directed_rows.push_back(mk_row(REQ_UPDATE, 0, IDX_MAX, 32'h7FFF_FFFF, 1, '0, 0));
    directed_rows.push_back(mk_row(REQ_UPDATE, IDX_MAX, 0, 32'h8000_0000, 1, '0, 0));
    directed_rows.push_back(mk_row(REQ_QUERY, 0, 0, '1, 1, 32'h7FFF_FFFF, 0));
    directed_rows.push_back(mk_row(REQ_QUERY, IDX_MAX, IDX_MAX, '1, 1, 32'h8000_0000, 0));
    directed_rows.push_back(mk_row(REQ_QUERY, 0, IDX_MAX, '0, 1, 32'hFFFF_FFFF, 0));
    directed_rows.push_back(mk_row(REQ_UPDATE, 1, 1, 32'h0000_0001, 1, '0, 0));
    directed_rows.push_back(mk_row(REQ_QUERY, 0, 1, '0, 1, 32'h8000_0000, 0));
    directed_rows.push_back(mk_row(REQ_QUERY, 1, 0, '0, 1, '0, 1));
    directed_rows.push_back(mk_row(REQ_QUERY, IDX_MAX, 0, '1, 1, '0, 1));
    directed_rows.push_back(mk_row(REQ_UPDATE, BLOCK_SIZE - 1, 0, '1, 1, '0, 0));
    directed_rows.push_back(mk_row(REQ_UPDATE, BLOCK_SIZE, 0, 32'h1234_5678, 1, '0, 0));
    directed_rows.push_back(mk_row(REQ_QUERY, BLOCK_SIZE - 1, BLOCK_SIZE, '0));
    directed_rows.push_back(mk_row(REQ_QUERY, 0, BLOCK_SIZE - 1, '0));
    directed_rows.push_back(mk_row(REQ_QUERY, 5, 900, '0));
    directed_rows.push_back(mk_row(REQ_UPDATE, 0, 0, '0, 1, '0, 0));
    directed_rows.push_back(mk_row(REQ_QUERY, 0, IDX_MAX, '0));
    directed_rows.push_back(mk_row(REQ_UPDATE, 500, 0, 32'hAAAA_AAAA, 1, '0, 0));
    directed_rows.push_back(mk_row(REQ_UPDATE, 500, IDX_MAX, 32'h5555_5555, 1, '0, 0));
    directed_rows.push_back(mk_row(REQ_QUERY, 480, 511, '0));
    directed_rows.push_back(mk_row(REQ_QUERY, BLOCK_SIZE + 1, 990, '0));
    directed_rows.push_back(mk_row(REQ_QUERY, 512, 511, '0, 1, '0, 1));
    directed_rows.push_back(mk_row(REQ_QUERY, 2 * BLOCK_SIZE, 3 * BLOCK_SIZE - 1, '0));
    foreach (directed_rows[i]) send_req(directed_rows[i]);
    wait_drained();

    // random mix, with calm stretches and periodic full drains
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) quiet = (n / 100 == 2) || ($urandom_range(0, 3) == 0);
      if (n % 150 == 149) wait_drained();
      send_req(random_row());
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("block_decomposed_range_sum_tb: clean");
    end else begin
      $display("block_decomposed_range_sum_tb: errors");
    end
    $finish;
  end

  // reply backpressure
  always @(posedge clk) begin
    if (rst) begin
      reply_stall <= 1'b0;
    end else if (stall_left > 0) begin
      reply_stall <= 1'b1;
      stall_left--;
    end else begin
      reply_stall <= 1'b0;
      stall_left = pick_gap();
    end
  end

  // reply check against the oldest owed reply
  always @(posedge clk) begin : reply_check
    reply_t want;
    if (!rst && reply_valid && !reply_stall) begin
      reply_no++;
      if (owed_replies.size() == 0) begin
        report_mismatch($sformatf("reply %0d unexpected: kind %0b sum %h bad %0b",
                                  reply_no, reply_kind, range_sum, bad_range));
      end else begin
        want = owed_replies.pop_front();
        if (reply_kind !== want.kind)
          report_mismatch($sformatf("reply %0d kind %0b, expected %0b",
                                    reply_no, reply_kind, want.kind));
        if (range_sum !== want.sum)
          report_mismatch($sformatf("reply %0d range_sum %h, expected %h",
                                    reply_no, range_sum, want.sum));
        if (bad_range !== want.bad)
          report_mismatch($sformatf("reply %0d bad_range %0b, expected %0b",
                                    reply_no, bad_range, want.bad));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (reply_valid && !reply_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("block_decomposed_range_sum_tb: errors");
        $finish;
      end
    end
  end

endmodule
